// ===== src/hrhv_pkg.sv =====
// ============================================================================
// HTTP request head validator package
// Shared types, character constants and the per-character update functions.
// ============================================================================
package hrhv_pkg;

  localparam int unsigned NUM_METHODS = 9;

  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_LF      = 8'h0A;
  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_LOWER_H = 8'h68;

  localparam logic [3:0] METHOD_NONE  = 4'd9;
  localparam logic [3:0] VERSION_LEN  = 4'd8;
  localparam logic [3:0] POSITION_MAX = 4'd15;

  // Method words, first character at index 0, padded with zero bytes.
  localparam logic [7:0] VERB_CHAR [NUM_METHODS][8] = '{
    '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"D", "E", "L", "E", "T", "E", 8'h00, 8'h00},
    '{"H", "E", "A", "D", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"O", "P", "T", "I", "O", "N", "S", 8'h00},
    '{"P", "A", "T", "C", "H", 8'h00, 8'h00, 8'h00},
    '{"T", "R", "A", "C", "E", 8'h00, 8'h00, 8'h00},
    '{"C", "O", "N", "N", "E", "C", "T", 8'h00}
  };
  localparam logic [3:0] VERB_LEN [NUM_METHODS] = '{
    4'd3, 4'd4, 4'd3, 4'd6, 4'd4, 4'd7, 4'd5, 4'd5, 4'd7
  };
  localparam logic [7:0] VERSION_CHAR [8] = '{"H", "T", "T", "P", "/", "1", ".", "1"};
  localparam logic [7:0] HOST_CHAR [4] = '{"h", "o", "s", "t"};

  typedef enum logic [1:0] {
    PH_METHOD  = 2'd0,
    PH_URI     = 2'd1,
    PH_VERSION = 2'd2,
    PH_HEADER  = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    HOST_LEAD = 3'd0,
    HOST_H    = 3'd1,
    HOST_HO   = 3'd2,
    HOST_HOS  = 3'd3,
    HOST_FULL = 3'd4,
    HOST_FAIL = 3'd5
  } host_e;

  typedef enum logic [1:0] {
    VERDICT_PENDING = 2'd0,
    VERDICT_ACCEPT  = 2'd1,
    VERDICT_BAD     = 2'd2
  } verdict_e;

  typedef struct packed {
    phase_e                 phase;
    logic                   held_cr;
    logic [NUM_METHODS-1:0] cand;
    logic [3:0]             pos;
    logic                   ver_mis;
    logic                   uri_empty;
    logic                   uri_bad;
    logic [1:0]             hex_pend;
    logic                   line_empty;
    logic                   colon_seen;
    host_e                  host_match;
    logic                   host_seen;
    verdict_e               decision;
    logic [3:0]             method;
  } state_t;

  // Result item, verdict in the lowest bits.
  typedef struct packed {
    logic [7:0] header_count;
    logic [3:0] method_code;
    verdict_e   verdict;
  } result_t;

  localparam state_t STATE_RESET = '{
    phase:      PH_METHOD,
    held_cr:    1'b0,
    cand:       {NUM_METHODS{1'b1}},
    pos:        4'd0,
    ver_mis:    1'b0,
    uri_empty:  1'b1,
    uri_bad:    1'b0,
    hex_pend:   2'd0,
    line_empty: 1'b1,
    colon_seen: 1'b0,
    host_match: HOST_LEAD,
    host_seen:  1'b0,
    decision:   VERDICT_PENDING,
    method:     METHOD_NONE
  };

  function automatic logic is_ws(logic [7:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return ((c >= "A") && (c <= "Z")) ? c + 8'd32 : c;
  endfunction

  function automatic logic uri_plain_ok(logic [7:0] c);
    logic ok;
    case (c)
      "-", ".", "_", "~", "/", ":", "@", "!", "$", "&",
      "+", ",", ";", "=", "(", ")", "*", "'": ok = 1'b1;
      default: ok = is_digit(c) || is_alpha(c);
    endcase
    return ok;
  endfunction

  function automatic logic [3:0] bump(logic [3:0] pos);
    return (pos != POSITION_MAX) ? pos + 4'd1 : pos;
  endfunction

  function automatic state_t start_line(state_t s);
    state_t r;
    r            = s;
    r.line_empty = 1'b1;
    r.colon_seen = 1'b0;
    r.host_match = HOST_LEAD;
    return r;
  endfunction

  // Effect of one ordinary character on the parse state.
  function automatic state_t plain_char(state_t s, logic [7:0] c);
    state_t r;
    r = s;
    case (s.phase)
      PH_METHOD: begin
        if (c == CHAR_SPACE) begin
          for (int k = 0; k < NUM_METHODS; k++) begin
            if (s.cand[k] && (VERB_LEN[k] == s.pos)) r.method = 4'(k);
          end
          r.phase = PH_URI;
          r.pos   = 4'd0;
        end else begin
          for (int k = 0; k < NUM_METHODS; k++) begin
            if ((s.pos >= VERB_LEN[k]) || (VERB_CHAR[k][s.pos[2:0]] != c)) r.cand[k] = 1'b0;
          end
          r.pos = bump(s.pos);
        end
      end
      PH_URI: begin
        if (c == CHAR_SPACE) begin
          if (s.hex_pend != 2'd0) r.uri_bad = 1'b1;
          r.phase = PH_VERSION;
          r.pos   = 4'd0;
        end else begin
          if (s.uri_empty) begin
            r.uri_empty = 1'b0;
            if (c != CHAR_SLASH) r.uri_bad = 1'b1;
          end
          if (s.hex_pend != 2'd0) begin
            if (!is_hex(c)) r.uri_bad = 1'b1;
            r.hex_pend = s.hex_pend - 2'd1;
          end else if (c == CHAR_PERCENT) begin
            r.hex_pend = 2'd2;
          end else if (!uri_plain_ok(c)) begin
            r.uri_bad = 1'b1;
          end
        end
      end
      PH_VERSION: begin
        if ((s.pos >= VERSION_LEN) || (VERSION_CHAR[s.pos[2:0]] != c)) r.ver_mis = 1'b1;
        r.pos = bump(s.pos);
      end
      default: begin
        r.line_empty = 1'b0;
        if (!s.colon_seen) begin
          if (c == CHAR_COLON) begin
            r.colon_seen = 1'b1;
          end else begin
            case (s.host_match)
              HOST_LEAD: begin
                if (!is_ws(c)) r.host_match = (to_lower(c) == CHAR_LOWER_H) ? HOST_H : HOST_FAIL;
              end
              HOST_H, HOST_HO, HOST_HOS: begin
                r.host_match = (to_lower(c) == HOST_CHAR[s.host_match[1:0]])
                             ? host_e'(s.host_match + 3'd1) : HOST_FAIL;
              end
              HOST_FULL: begin
                if (!is_ws(c)) r.host_match = HOST_FAIL;
              end
              default: r.host_match = s.host_match;
            endcase
          end
        end
      end
    endcase
    return r;
  endfunction

  // Effect of a CR LF pair on the parse state.
  function automatic state_t close_line(state_t s);
    state_t r;
    r = s;
    if (s.phase != PH_HEADER) begin
      if ((s.phase != PH_VERSION) || (s.method == METHOD_NONE) || s.uri_empty || s.uri_bad ||
          s.ver_mis || (s.pos != VERSION_LEN)) begin
        r.decision = VERDICT_BAD;
      end else begin
        r       = start_line(s);
        r.phase = PH_HEADER;
      end
    end else if (s.line_empty) begin
      r.decision = s.host_seen ? VERDICT_ACCEPT : VERDICT_BAD;
    end else if (!s.colon_seen) begin
      r.decision = VERDICT_BAD;
    end else begin
      r = start_line(s);
      if (s.host_match == HOST_FULL) r.host_seen = 1'b1;
    end
    return r;
  endfunction

  // End of text: a held CR is an ordinary character, then the verdict is settled.
  function automatic state_t finish(state_t s);
    state_t r;
    r = s;
    if (s.held_cr) begin
      r.held_cr = 1'b0;
      r         = plain_char(r, CHAR_CR);
    end
    r.decision = ((r.phase == PH_HEADER) && r.host_seen) ? VERDICT_ACCEPT : VERDICT_BAD;
    return r;
  endfunction

endpackage

// ===== src/hrhv_step.sv =====
// ============================================================================
// HTTP request head validator update logic
// Next parse state, header count and result for one registered input byte.
// ============================================================================
module hrhv_step #(
  parameter int unsigned COUNT_BITS = 8
) (
  input  hrhv_pkg::state_t        state_i,
  input  logic [COUNT_BITS-1:0]   lines_i,
  input  logic [7:0]              text_byte_i,
  input  logic                    final_byte_i,
  output hrhv_pkg::state_t        state_o,
  output logic [COUNT_BITS-1:0]   lines_o,
  output hrhv_pkg::result_t       result_o
);
  import hrhv_pkg::*;

  localparam int unsigned WIDE_BITS = COUNT_BITS + 8;

  always_comb begin
    state_t                s;
    logic                  count_up;
    logic [COUNT_BITS-1:0] lines_new;
    logic [WIDE_BITS-1:0]  lines_wide;

    s        = state_i;
    count_up = 1'b0;

    if (state_i.decision == VERDICT_PENDING) begin
      if (text_byte_i == CHAR_NUL) begin
        s = finish(s);
      end else begin
        if (s.held_cr) begin
          s.held_cr = 1'b0;
          if (text_byte_i == CHAR_LF) begin
            // Only a completed header line with a colon adds to the count.
            count_up = (s.phase == PH_HEADER) && !s.line_empty && s.colon_seen;
            s        = close_line(s);
          end else begin
            s = plain_char(s, CHAR_CR);
            if (text_byte_i == CHAR_CR) s.held_cr = 1'b1;
            else                        s = plain_char(s, text_byte_i);
          end
        end else if (text_byte_i == CHAR_CR) begin
          s.held_cr = 1'b1;
        end else begin
          s = plain_char(s, text_byte_i);
        end
        if (final_byte_i && (s.decision == VERDICT_PENDING)) s = finish(s);
      end
    end

    lines_new = (count_up && (lines_i != {COUNT_BITS{1'b1}})) ? lines_i + COUNT_BITS'(1)
                                                               : lines_i;
    lines_wide = WIDE_BITS'(lines_new);

    result_o.verdict      = s.decision;
    result_o.method_code  = s.method;
    result_o.header_count = (lines_wide > WIDE_BITS'(255)) ? 8'hFF : lines_wide[7:0];

    // The last byte of a request leaves everything as after reset.
    state_o = final_byte_i ? STATE_RESET : s;
    lines_o = final_byte_i ? '0 : lines_new;
  end

endmodule

// ===== src/http_request_head_validator.sv =====
// ============================================================================
// HTTP request head validator
// Checks an HTTP/1.1 request line and header block byte by byte.
// ============================================================================
//
// Channel  Direction  tdata (lowest bit first)                          tlast
// -------  ---------  ------------------------------------------------  ----------
// s_axis   in         [7:0] text_byte                                   final_byte
// m_axis   out        [1:0] verdict, [5:2] method_code,                 unused
//                     [13:6] header_count, [15:14] zero
//
// One byte is taken per cycle while the result side is not stalled, and every
// byte produces exactly one result transfer. A byte is held in the input
// register, then the update logic moves the parse state on and loads the result
// register, which presents the result on m_axis. The parse state feeds back
// through that single update stage, which sets the one-byte-per-cycle rate.
// Reset is asynchronous and active low and leaves the parser at the start of
// a request. While a result waits in the output register, the next byte is
// still taken into the input register; only when both are full does the input
// side stall.
module http_request_head_validator #(
  parameter int unsigned COUNT_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tlast,   // final_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // verdict, method_code, header_count, zero pad
);
  import hrhv_pkg::*;

  // Input register.
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // Parse state.
  state_t                state_q, state_d;
  logic [COUNT_BITS-1:0] lines_q, lines_d;

  // Result register.
  logic    out_valid_q;
  result_t out_data_q;
  result_t result;

  logic out_free;
  logic advance;

  // The result register can take a new item when it is empty or being drained.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  hrhv_step #(
    .COUNT_BITS(COUNT_BITS)
  ) u_step (
    .state_i      (state_q),
    .lines_i      (lines_q),
    .text_byte_i  (in_byte_q),
    .final_byte_i (in_last_q),
    .state_o      (state_d),
    .lines_o      (lines_d),
    .result_o     (result)
  );

  // Input stage: loads whenever the byte it holds moves on or it is empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // Parse state advances exactly once for each byte that reaches the result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RESET;
      lines_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
      lines_q <= lines_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_data_q};

  // A settled verdict holds until the last byte of the request.
  a_verdict_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !in_last_q && (state_q.decision != VERDICT_PENDING))
      |=> (state_q.decision == $past(state_q.decision)))
    else $error("verdict changed before the end of the request");

  // The last byte of a request returns the parser to its start.
  a_final_restarts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_last_q) |=> ((state_q == STATE_RESET) && (lines_q == '0)))
    else $error("parser not back at the start after the last byte");

  // A waiting byte is neither lost nor overwritten while the result side stalls.
  a_input_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_free) |=> (in_valid_q && $stable(in_byte_q) && $stable(in_last_q)))
    else $error("input register changed during a stall");

  // The method code is only ever a known word or the none marker.
  a_method_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q.method_code <= METHOD_NONE))
    else $error("method code out of range");

endmodule
